// ===== design/tks_pkg.sv =====
// shared types and constants of the key table search block
// used by every module of the block; depends on nothing

package tks_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int MAX_MATCHES_DEF = 16;

  // fixed field widths
  localparam int COUNT_W = 8;
  localparam int INDEX_W = 7;
  localparam int KEY_W   = 32;
  localparam int POS_W   = 8;

  // front queue
  localparam int QUEUE_DEPTH = 2;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_ENTRY_COUNT = 1'b0;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_FIRST = 2'd1,
    MODE_ALL   = 2'd2,
    MODE_BIN   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                    mode;
    logic [INDEX_W-1:0]       index;
    logic signed [KEY_W-1:0]  key;
  } item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             last;
    logic             truncated;
  } result_t;

  // item after classification in the front part
  typedef struct packed {
    logic                    is_load;
    logic                    load_ok;
    mode_t                   mode;
    logic [INDEX_W-1:0]      index;
    logic signed [KEY_W-1:0] key;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BIN_RD,
    ST_BIN_CMP,
    ST_FLUSH
  } state_t;

endpackage

// ===== design/table_key_search.sv =====
// Key table search. Load items write a key at an index; search items look
// up a key among the first entry_count entries (saturated at the table
// depth) by first-match scan, all-match scan or bisection. Items go through
// a two-entry front queue into a sequencer that owns the key memory, which
// has one registered read port, so the scan reads one entry per cycle
// while the result side does not stall; a binary search reads and then
// compares the middle entry in each probe, and a load is written from the
// idle state. An all-match search puts each match into the output register
// in the scan step that finds the next one, and, unless the match limit
// cuts it short, its final result from the flush state once the scan ends.
// The entry_count register sits at byte address 0; the user must write it
// only while no search is in flight, as the block itself does not enforce
// this. Entries never loaded read back as unknown data.
// depends on tks_pkg, tks_front and tks_engine

module table_key_search #(
  parameter int TABLE_DEPTH = tks_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_MATCHES = tks_pkg::MAX_MATCHES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  tks_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output tks_pkg::result_t              result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tks_pkg::PADDR_W-1:0]   paddr,
  input  logic [tks_pkg::PDATA_W-1:0]   pwdata,
  output logic [tks_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [tks_pkg::COUNT_W-1:0] entry_count;
  logic                        cmd_valid;
  logic                        cmd_ready;
  tks_pkg::cmd_t               cmd;
  logic                        reg_hit;

  // word index of the register
  assign reg_hit = (paddr[tks_pkg::PADDR_W-1] == tks_pkg::REG_ENTRY_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? tks_pkg::PDATA_W'(entry_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (psel && penable && pwrite && reg_hit) begin
      entry_count <= pwdata[tks_pkg::COUNT_W-1:0];
    end
  end

  tks_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  tks_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_MATCHES (MAX_MATCHES)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .entry_count  (entry_count),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== design/tks_front.sv =====
// front part: accepts items, classifies them and queues them for the engine
// depends on tks_pkg

module tks_front #(
  parameter int TABLE_DEPTH = tks_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  tks_pkg::item_t item,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output tks_pkg::cmd_t  cmd
);

  localparam int QD = tks_pkg::QUEUE_DEPTH;
  localparam int QW = $clog2(QD);

  tks_pkg::cmd_t  queue [QD];
  logic [QW-1:0]  wr_ptr;
  logic [QW-1:0]  rd_ptr;
  logic [QW:0]    fill;
  tks_pkg::cmd_t  incoming;
  logic           push;
  logic           pop;

  always_comb begin
    incoming.is_load = (item.mode == tks_pkg::MODE_LOAD);
    // loads beyond the table are dropped by the engine
    incoming.load_ok = (32'(item.index) < TABLE_DEPTH);
    incoming.mode    = item.mode;
    incoming.index   = item.index;
    incoming.key     = item.key;
  end

  assign item_ready = (fill != (QW+1)'(QD));
  assign cmd_valid  = (fill != '0);
  assign cmd        = queue[rd_ptr];
  assign push       = item_valid && item_ready;
  assign pop        = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== design/tks_engine.sv =====
// back part: key memory and search sequencer with its output register
// depends on tks_pkg

module tks_engine #(
  parameter int TABLE_DEPTH = tks_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_MATCHES = tks_pkg::MAX_MATCHES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [tks_pkg::COUNT_W-1:0]  entry_count,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  tks_pkg::cmd_t                cmd,
  output logic                         result_valid,
  input  logic                         result_ready,
  output tks_pkg::result_t             result
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = tks_pkg::COUNT_W;
  localparam int KW   = tks_pkg::KEY_W;
  localparam int PW   = tks_pkg::POS_W;
  localparam int CNTW = $clog2(MAX_MATCHES + 1);

  logic [KW-1:0] mem [TABLE_DEPTH];
  logic [KW-1:0] rdata;

  tks_pkg::state_t state, state_next;
  tks_pkg::mode_t  mode, mode_next;
  logic signed [KW-1:0] key, key_next;
  logic [CW-1:0]   n, n_next;
  logic [CW-1:0]   rd_i, rd_i_next;
  logic [CW-1:0]   cmp_i, cmp_i_next;
  logic            pend, pend_next;
  logic            held_valid, held_valid_next;
  logic [PW-1:0]   held_pos, held_pos_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic [CW-1:0]   lo, lo_next;
  logic [CW-1:0]   hi_x, hi_x_next;
  logic [CW-1:0]   mid, mid_next;

  logic [CW-1:0]    n_in;
  logic [CW:0]      mid_sum;
  logic [CW-1:0]    mid_c;
  logic             advance;
  logic             match;
  logic             last_cmp;
  logic [PW-1:0]    cmp_pos;
  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    raddr;
  logic             emit;
  tks_pkg::result_t emit_data;

  // count saturates at the table depth
  assign n_in = (32'(entry_count) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : entry_count;

  // floor of (low + high) / 2 with high kept as an exclusive bound
  assign mid_sum  = {1'b0, lo} + {1'b0, hi_x} - 1'b1;
  assign mid_c    = mid_sum[CW:1];

  // the scan, compare and flush steps move only when the output register can take a result
  assign advance  = !result_valid || result_ready;
  assign match    = pend && (rdata == key);
  assign last_cmp = pend && (cmp_i == n - 1'b1);
  assign cmp_pos  = PW'(cmp_i) + 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(cmd.index)] <= cmd.key;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tks_pkg::ST_IDLE: begin
        if (cmd_valid && !cmd.is_load) begin
          if (cmd.mode == tks_pkg::MODE_BIN) begin
            state_next = tks_pkg::ST_BIN_RD;
          end else if (n_in == '0) begin
            state_next = tks_pkg::ST_FLUSH;
          end else begin
            state_next = tks_pkg::ST_SCAN;
          end
        end
      end
      tks_pkg::ST_SCAN: begin
        if (advance && match && mode == tks_pkg::MODE_FIRST) begin
          state_next = tks_pkg::ST_IDLE;
        end else if (advance && match && held_valid && cnt == CNTW'(MAX_MATCHES)) begin
          state_next = tks_pkg::ST_IDLE;
        end else if (advance && last_cmp) begin
          state_next = tks_pkg::ST_FLUSH;
        end
      end
      tks_pkg::ST_BIN_RD: begin
        state_next = (lo < hi_x) ? tks_pkg::ST_BIN_CMP : tks_pkg::ST_FLUSH;
      end
      tks_pkg::ST_BIN_CMP: begin
        if (advance) begin
          state_next = (rdata == key) ? tks_pkg::ST_IDLE : tks_pkg::ST_BIN_RD;
        end
      end
      tks_pkg::ST_FLUSH: begin
        if (advance) begin
          state_next = tks_pkg::ST_IDLE;
        end
      end
      default: state_next = tks_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mode_next       = mode;
    key_next        = key;
    n_next          = n;
    rd_i_next       = rd_i;
    cmp_i_next      = cmp_i;
    pend_next       = pend;
    held_valid_next = held_valid;
    held_pos_next   = held_pos;
    cnt_next        = cnt;
    lo_next         = lo;
    hi_x_next       = hi_x;
    mid_next        = mid;
    cmd_ready       = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    raddr           = '0;
    emit            = 1'b0;
    emit_data       = '0;
    case (state)
      tks_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd.is_load) begin
            mem_we = cmd.load_ok;
          end else begin
            mode_next       = cmd.mode;
            key_next        = cmd.key;
            n_next          = n_in;
            rd_i_next       = '0;
            pend_next       = 1'b0;
            held_valid_next = 1'b0;
            cnt_next        = '0;
            lo_next         = '0;
            hi_x_next       = n_in;
          end
        end
      end
      tks_pkg::ST_SCAN: begin
        if (advance) begin
          // issue the next read while comparing the previous entry
          if (rd_i < n) begin
            mem_re     = 1'b1;
            raddr      = AW'(rd_i);
            pend_next  = 1'b1;
            cmp_i_next = rd_i;
            rd_i_next  = rd_i + 1'b1;
          end else begin
            pend_next  = 1'b0;
          end
          if (match) begin
            if (mode == tks_pkg::MODE_FIRST) begin
              emit      = 1'b1;
              emit_data = '{found: 1'b1, position: cmp_pos, last: 1'b1, truncated: 1'b0};
            end else if (held_valid) begin
              // a match after the held one: the held result is not the last
              emit = 1'b1;
              if (cnt == CNTW'(MAX_MATCHES)) begin
                emit_data = '{found: 1'b1, position: held_pos, last: 1'b1,
                              truncated: 1'b1};
              end else begin
                emit_data = '{found: 1'b1, position: held_pos, last: 1'b0,
                              truncated: 1'b0};
                held_pos_next = cmp_pos;
                cnt_next      = cnt + 1'b1;
              end
            end else begin
              held_valid_next = 1'b1;
              held_pos_next   = cmp_pos;
              cnt_next        = CNTW'(1);
            end
          end
        end
      end
      tks_pkg::ST_BIN_RD: begin
        if (lo < hi_x) begin
          mem_re   = 1'b1;
          raddr    = AW'(mid_c);
          mid_next = mid_c;
        end
      end
      tks_pkg::ST_BIN_CMP: begin
        if (advance) begin
          if (rdata == key) begin
            emit      = 1'b1;
            emit_data = '{found: 1'b1, position: PW'(mid) + 1'b1, last: 1'b1,
                          truncated: 1'b0};
          end else if ($signed(rdata) < key) begin
            lo_next = mid + 1'b1;
          end else begin
            hi_x_next = mid;
          end
        end
      end
      tks_pkg::ST_FLUSH: begin
        if (advance) begin
          emit = 1'b1;
          if (held_valid) begin
            emit_data = '{found: 1'b1, position: held_pos, last: 1'b1, truncated: 1'b0};
          end else begin
            emit_data = '{found: 1'b0, position: '0, last: 1'b1, truncated: 1'b0};
          end
        end
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mode     <= mode_next;
    key      <= key_next;
    n        <= n_next;
    rd_i     <= rd_i_next;
    cmp_i    <= cmp_i_next;
    held_pos <= held_pos_next;
    cnt      <= cnt_next;
    lo       <= lo_next;
    hi_x     <= hi_x_next;
    mid      <= mid_next;
    if (emit) begin
      result <= emit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tks_pkg::ST_IDLE;
      pend         <= 1'b0;
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend       <= pend_next;
      held_valid <= held_valid_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/tks_checker.sv =====
// port-level checks of the key table search block and their binding
// depends on tks_pkg and table_key_search

module tks_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input tks_pkg::result_t result
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // a miss is always a lone final result
  a_miss_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |->
      result.last && result.position == '0 && !result.truncated)
    else $error("miss result malformed");

  // truncation is flagged only on the final match
  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.truncated |-> result.last && result.found)
    else $error("truncation flag off the final match");

  // a hit carries a 1-based position
  a_hit_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.found |-> result.position != '0)
    else $error("hit with zero position");

endmodule

bind table_key_search tks_checker u_tks_checker (.*);
